FILE: src/tcce_pkg.sv
// Shared constants, codes and types of the text console cursor engine.
package tcce_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int POS_W   = 11;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int OUTSTANDING_MAX = QDEPTH + 2;
    localparam int OUTST_W = $clog2(OUTSTANDING_MAX + 1);

    localparam int KIND_W    = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [KIND_W-1:0] KIND_PUT       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_READ      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WR_CHAR   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WR_COLOR  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_COLOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TAB_STOP      = 1'b1;

    localparam logic [7:0] CH_NULL    = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_RETURN  = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic [7:0] DEFAULT_COLOR_RST = 8'h07;
    localparam logic [3:0] TAB_STOP_RST      = 4'd4;
    localparam logic [3:0] TAB_MIN           = 4'd1;
    localparam logic [3:0] TAB_MAX           = 4'd8;

    typedef enum logic [3:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_RETURN,
        OP_TAB,
        OP_CLEAR,
        OP_READ,
        OP_WR_CHAR,
        OP_WR_COLOR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [7:0]       ch;
        logic [7:0]       color;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } cmd_t;

    typedef struct packed {
        logic init_busy;
    } back_status_t;

endpackage

FILE: src/tcce_front.sv
// Front end: input beat acceptance and classification into console commands.
module tcce_front (
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [tcce_pkg::KIND_W-1:0]     s_kind,
    input  logic [7:0]                      s_char_code,
    input  logic [7:0]                      s_cell_color,
    input  logic [6:0]                      s_cell_column,
    input  logic [4:0]                      s_cell_row,
    input  tcce_pkg::back_status_t          status,
    output logic                            q_valid,
    input  logic                            q_ready,
    output tcce_pkg::cmd_t                  q_cmd
);
    import tcce_pkg::*;

    logic on_screen;
    op_t  op;

    assign on_screen = (int'(s_cell_column) < COLUMNS) && (int'(s_cell_row) < ROWS);

    always_comb begin
        case (s_kind)
            KIND_PUT: begin
                case (s_char_code)
                    CH_NEWLINE: op = OP_NEWLINE;
                    CH_RETURN:  op = OP_RETURN;
                    CH_TAB:     op = OP_TAB;
                    default:    op = OP_PUT;
                endcase
            end
            KIND_CLEAR:    op = OP_CLEAR;
            KIND_READ:     op = on_screen ? OP_READ : OP_NOP;
            KIND_WR_CHAR:  op = on_screen ? OP_WR_CHAR : OP_NOP;
            KIND_WR_COLOR: op = on_screen ? OP_WR_COLOR : OP_NOP;
            default:       op = OP_NOP;
        endcase
    end

    assign q_cmd.op    = op;
    assign q_cmd.ch    = s_char_code;
    assign q_cmd.color = s_cell_color;
    assign q_cmd.col   = COL_W'(s_cell_column);
    assign q_cmd.row   = ROW_W'(s_cell_row);

    assign s_ready = q_ready && !status.init_busy;
    assign q_valid = s_valid && !status.init_busy;

endmodule

FILE: src/tcce_queue.sv
// Command queue between the front end and the execution back end.
module tcce_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  tcce_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output tcce_pkg::cmd_t out_cmd
);
    import tcce_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != QCNT_W'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

FILE: src/tcce_back.sv
// Back end: screen memory, cursor, scroll and clear sweeps, result register.
module tcce_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  tcce_pkg::cmd_t                    q_cmd,
    input  logic                              cfg_we,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                        cfg_wdata,
    output tcce_pkg::back_status_t            status,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tcce_pkg::POS_W-1:0]        m_cursor_position,
    output logic [7:0]                        m_read_char,
    output logic [7:0]                        m_read_color
);
    import tcce_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DECODE = 8'b0000_0010,
        ST_ACCESS = 8'b0000_0100,
        ST_TABDIV = 8'b0000_1000,
        ST_PUT    = 8'b0001_0000,
        ST_FILL   = 8'b0010_0000,
        ST_NEXT   = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic              init_reg, init_next;
    cmd_t              cmd_reg, cmd_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ROW_W-1:0]  prow_reg, prow_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [ROW_W-1:0]  cprow_reg, cprow_next;
    logic [COL_W-1:0]  rem_reg, rem_next;
    logic [3:0]        rep_reg, rep_next;
    logic [ROW_W-1:0]  fill_row_reg, fill_row_next;
    logic [COL_W-1:0]  fill_col_reg, fill_col_next;
    logic              fill_all_reg, fill_all_next;
    logic [7:0]        color_def_reg, color_def_next;
    logic [3:0]        tab_reg, tab_next;
    logic              m_valid_reg, m_valid_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]        rchar_reg, rchar_next;
    logic [7:0]        rcolor_reg, rcolor_next;

    logic [7:0]        char_mem  [CELLS];
    logic [7:0]        color_mem [CELLS];
    logic [7:0]        char_q, color_q;
    logic              char_we, color_we;
    logic [7:0]        char_wd, color_wd;
    logic [ROW_W-1:0]  addr_row;
    logic [COL_W-1:0]  addr_col;
    logic [ADDR_W-1:0] mem_addr;
    logic [ADDR_W-1:0] cur_pos;
    logic [ROW_W:0]    row_sum;
    logic [3:0]        stop;
    logic              pop;

    assign mem_addr = ADDR_W'(ADDR_W'(addr_row) * ADDR_W'(COLUMNS)) + ADDR_W'(addr_col);
    assign cur_pos  = ADDR_W'(ADDR_W'(row_reg) * ADDR_W'(COLUMNS)) + ADDR_W'(col_reg);
    assign row_sum  = {1'b0, cmd_reg.row} + {1'b0, top_reg};
    assign stop     = (tab_reg < TAB_MIN) ? TAB_MIN : ((tab_reg > TAB_MAX) ? TAB_MAX : tab_reg);

    always_comb begin
        state_next     = state_reg;
        init_next      = init_reg;
        cmd_next       = cmd_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        prow_next      = prow_reg;
        top_next       = top_reg;
        cprow_next     = cprow_reg;
        rem_next       = rem_reg;
        rep_next       = rep_reg;
        fill_row_next  = fill_row_reg;
        fill_col_next  = fill_col_reg;
        fill_all_next  = fill_all_reg;
        color_def_next = color_def_reg;
        tab_next       = tab_reg;
        m_valid_next   = m_valid_reg;
        pos_next       = pos_reg;
        rchar_next     = rchar_reg;
        rcolor_next    = rcolor_reg;
        char_we        = 1'b0;
        color_we       = 1'b0;
        char_wd        = CH_NULL;
        color_wd       = init_reg ? DEFAULT_COLOR_RST : color_def_reg;
        addr_row       = prow_reg;
        addr_col       = col_reg;
        pop            = 1'b0;

        if (cfg_we) begin
            case (cfg_index)
                REG_DEFAULT_COLOR: color_def_next = cfg_wdata;
                REG_TAB_STOP:      tab_next = cfg_wdata[3:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_valid && !m_valid_reg) begin
                    pop      = 1'b1;
                    cmd_next = q_cmd;
                    case (q_cmd.op)
                        OP_PUT, OP_NEWLINE: begin
                            rep_next   = 4'd1;
                            state_next = ST_PUT;
                        end
                        OP_RETURN: begin
                            col_next   = '0;
                            state_next = ST_DONE;
                        end
                        OP_TAB: begin
                            rem_next   = col_reg;
                            state_next = ST_TABDIV;
                        end
                        OP_CLEAR: begin
                            col_next      = '0;
                            row_next      = '0;
                            prow_next     = '0;
                            top_next      = '0;
                            fill_row_next = '0;
                            fill_col_next = '0;
                            fill_all_next = 1'b1;
                            state_next    = ST_FILL;
                        end
                        OP_READ, OP_WR_CHAR, OP_WR_COLOR: state_next = ST_DECODE;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_DECODE: begin
                cprow_next = (row_sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(row_sum - (ROW_W+1)'(ROWS))
                                                           : ROW_W'(row_sum);
                state_next = ST_ACCESS;
            end
            ST_ACCESS: begin
                addr_row = cprow_reg;
                addr_col = cmd_reg.col;
                if (cmd_reg.op == OP_WR_CHAR) begin
                    char_we = 1'b1;
                    char_wd = cmd_reg.ch;
                end
                if (cmd_reg.op == OP_WR_COLOR) begin
                    color_we = 1'b1;
                    color_wd = cmd_reg.color;
                end
                state_next = ST_DONE;
            end
            ST_TABDIV: begin
                if ({1'b0, rem_reg} >= (COL_W+1)'(stop)) begin
                    rem_next = COL_W'({1'b0, rem_reg} - (COL_W+1)'(stop));
                end else begin
                    rep_next   = stop - 4'(rem_reg);
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                if (cmd_reg.op != OP_NEWLINE) begin
                    char_we = 1'b1;
                    char_wd = (cmd_reg.op == OP_TAB) ? CH_SPACE : cmd_reg.ch;
                end
                if ((cmd_reg.op == OP_NEWLINE) || (col_reg == COL_W'(COLUMNS - 1))) begin
                    col_next  = '0;
                    prow_next = (prow_reg == ROW_W'(ROWS - 1)) ? '0 : prow_reg + 1'b1;
                    if (row_reg == ROW_W'(ROWS - 1)) begin
                        top_next      = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + 1'b1;
                        fill_row_next = top_reg;
                        fill_col_next = '0;
                        fill_all_next = 1'b0;
                        state_next    = ST_FILL;
                    end else begin
                        row_next   = row_reg + 1'b1;
                        state_next = ST_NEXT;
                    end
                end else begin
                    col_next   = col_reg + 1'b1;
                    state_next = ST_NEXT;
                end
            end
            ST_FILL: begin
                addr_row = fill_row_reg;
                addr_col = fill_col_reg;
                char_we  = 1'b1;
                color_we = 1'b1;
                if (fill_col_reg == COL_W'(COLUMNS - 1)) begin
                    fill_col_next = '0;
                    if (fill_all_reg && (fill_row_reg != ROW_W'(ROWS - 1))) begin
                        fill_row_next = fill_row_reg + 1'b1;
                    end else if (init_reg) begin
                        init_next  = 1'b0;
                        state_next = ST_IDLE;
                    end else if (cmd_reg.op == OP_CLEAR) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_NEXT;
                    end
                end else begin
                    fill_col_next = fill_col_reg + 1'b1;
                end
            end
            ST_NEXT: begin
                if (rep_reg > 4'd1) begin
                    rep_next   = rep_reg - 4'd1;
                    state_next = ST_PUT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                m_valid_next = 1'b1;
                pos_next     = POS_W'(cur_pos);
                rchar_next   = (cmd_reg.op == OP_READ) ? char_q : 8'h00;
                rcolor_next  = (cmd_reg.op == OP_READ) ? color_q : 8'h00;
                state_next   = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_FILL;
            init_reg      <= 1'b1;
            col_reg       <= '0;
            row_reg       <= '0;
            prow_reg      <= '0;
            top_reg       <= '0;
            fill_row_reg  <= '0;
            fill_col_reg  <= '0;
            fill_all_reg  <= 1'b1;
            rep_reg       <= '0;
            color_def_reg <= DEFAULT_COLOR_RST;
            tab_reg       <= TAB_STOP_RST;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            prow_reg      <= prow_next;
            top_reg       <= top_next;
            fill_row_reg  <= fill_row_next;
            fill_col_reg  <= fill_col_next;
            fill_all_reg  <= fill_all_next;
            rep_reg       <= rep_next;
            color_def_reg <= color_def_next;
            tab_reg       <= tab_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        cprow_reg  <= cprow_next;
        rem_reg    <= rem_next;
        pos_reg    <= pos_next;
        rchar_reg  <= rchar_next;
        rcolor_reg <= rcolor_next;
    end

    always_ff @(posedge aclk) begin
        if (char_we) begin
            char_mem[mem_addr] <= char_wd;
        end
        char_q <= char_mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (color_we) begin
            color_mem[mem_addr] <= color_wd;
        end
        color_q <= color_mem[mem_addr];
    end

    assign q_ready            = pop;
    assign status.init_busy   = init_reg;
    assign m_valid            = m_valid_reg;
    assign m_cursor_position  = pos_reg;
    assign m_read_char        = rchar_reg;
    assign m_read_color       = rcolor_reg;

endmodule

FILE: src/text_console_cursor_engine.sv
// Top level: front end, command queue and back end of the text console.
// Put char and newline step IDLE, PUT, NEXT, DONE; return IDLE, DONE; read and direct writes
// IDLE, DECODE, ACCESS, DONE. A scroll adds a one-row sweep (80 columns), a tab up to 8 puts
// plus a column-mod loop; clear sweeps all 2000 cells through the single-port screen memory.
// Throughput: one item at a time in the back end; the queue holds 2 further beats.
// Reset: synchronous; a full-screen sweep then blanks the screen, s_ready stays low meanwhile.
module text_console_cursor_engine (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [tcce_pkg::KIND_W-1:0]     s_kind,
    input  logic [7:0]                      s_char_code,
    input  logic [7:0]                      s_cell_color,
    input  logic [6:0]                      s_cell_column,
    input  logic [4:0]                      s_cell_row,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tcce_pkg::POS_W-1:0]      m_cursor_position,
    output logic [7:0]                      m_read_char,
    output logic [7:0]                      m_read_color,
    input  logic                            cfg_we,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                      cfg_wdata
);
    import tcce_pkg::*;

    back_status_t status;
    logic         fq_valid, fq_ready;
    cmd_t         fq_cmd;
    logic         qb_valid, qb_ready;
    cmd_t         qb_cmd;

    tcce_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_char_code   (s_char_code),
        .s_cell_color  (s_cell_color),
        .s_cell_column (s_cell_column),
        .s_cell_row    (s_cell_row),
        .status        (status),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_cmd         (fq_cmd)
    );

    tcce_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    tcce_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_valid           (qb_valid),
        .q_ready           (qb_ready),
        .q_cmd             (qb_cmd),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .status            (status),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cursor_position (m_cursor_position),
        .m_read_char       (m_read_char),
        .m_read_color      (m_read_color)
    );

endmodule

FILE: src/tcce_checker.sv
// Port-level checker for the text console cursor engine, with its bind.
module tcce_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [tcce_pkg::POS_W-1:0]      m_cursor_position,
    input logic [7:0]                      m_read_char,
    input logic [7:0]                      m_read_color
);
    import tcce_pkg::*;

    logic [OUTST_W-1:0] outstanding_reg, outstanding_next;
    logic               s_beat, m_beat;

    assign s_beat = s_valid && s_ready;
    assign m_beat = m_valid && m_ready;

    always_comb begin
        outstanding_next = outstanding_reg;
        if (s_beat && !m_beat) begin
            outstanding_next = outstanding_reg + 1'b1;
        end else if (m_beat && !s_beat) begin
            outstanding_next = outstanding_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg <= '0;
        end else begin
            outstanding_reg <= outstanding_next;
        end
    end

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cursor_position)
                                && $stable(m_read_char) && $stable(m_read_color))
        else $error("result beat changed while stalled");

    a_cursor_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_cursor_position) < CELLS))
        else $error("cursor position beyond the screen");

    a_no_spurious_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (outstanding_reg != '0))
        else $error("result beat without an accepted item");

    a_bounded_backlog: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(outstanding_reg) <= OUTSTANDING_MAX)
        else $error("more items in flight than the block can hold");

    a_blank_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input taken before the reset sweep");

endmodule

bind text_console_cursor_engine tcce_checker u_tcce_checker (.*);
